### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset
`define CHK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dktt_pkg.sv
// ----------------------------------------------------------------------------
// dktt_pkg
// Types and constants of the deduplicating top-k network table.
// ----------------------------------------------------------------------------
package dktt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int NAME_WORD_W     = 64;
   localparam int NAME_BYTES      = 32;
   localparam int NAME_W          = NAME_BYTES * 8;
   localparam int SIG_W           = 8;
   localparam int OP_W            = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   // one table row
   typedef struct packed {
      logic [NAME_W-1:0]       name;
      logic signed [SIG_W-1:0] sig;
      logic                    sec;
   } entry_type;

endpackage

### rtl/dedup_top_k_network_table.sv
// ----------------------------------------------------------------------------
// dedup_top_k_network_table
// Bounded table of scanned networks with name dedup, weakest-entry
// replacement and a strongest-first report.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one word per command: clear, insert or report.
//    req_stall is high while a command is in progress; the block takes one
//    command at a time.
//  - Insert walks the table through its single-port row memory, one stored
//    entry a cycle with the compare in the cycle after the read. Names are
//    cut at the first zero byte before compare and store; an empty name is
//    dropped.
//  - Report emits one rsp_ word per entry, strongest first, ties in slot
//    order, rsp_last on the final word. Each word is one selection pass over
//    the table. An empty table gives one word with rsp_entry_valid low and
//    rsp_last high.
//  - rsp_ words sit in an output register; when the receiver stalls, the
//    report pass holds until that register frees. The next command is taken
//    while the final word of a report still waits.
//  - Reset (synchronous, active high) empties the table and drops any
//    pending output word. Row contents are not cleared.
// ----------------------------------------------------------------------------
module dedup_top_k_network_table
   import dktt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [NAME_WORD_W-1:0]  req_name_word0,
   input  logic [NAME_WORD_W-1:0]  req_name_word1,
   input  logic [NAME_WORD_W-1:0]  req_name_word2,
   input  logic [NAME_WORD_W-1:0]  req_name_word3,
   input  logic signed [SIG_W-1:0] req_signal_dbm,
   input  logic                    req_secure_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NAME_WORD_W-1:0]  rsp_out_word0,
   output logic [NAME_WORD_W-1:0]  rsp_out_word1,
   output logic [NAME_WORD_W-1:0]  rsp_out_word2,
   output logic [NAME_WORD_W-1:0]  rsp_out_word3,
   output logic signed [SIG_W-1:0] rsp_out_signal,
   output logic                    rsp_out_secure,
   output logic                    rsp_entry_valid,
   output logic                    rsp_last
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INS  = 2'd1;
   localparam logic [1:0] ST_RPT  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // table memory
   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // control and datapath registers
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   entry_type        ins_ff, ins_in;
   logic             weak_any_ff, weak_any_in;
   logic [IDX_W-1:0] weak_idx_ff, weak_idx_in;
   logic signed [SIG_W-1:0] weak_sig_ff, weak_sig_in;
   logic             best_any_ff, best_any_in;
   entry_type        best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             have_prev_ff, have_prev_in;
   logic signed [SIG_W-1:0] prev_sig_ff, prev_sig_in;
   logic [IDX_W-1:0] prev_idx_ff, prev_idx_in;
   logic [CNT_W-1:0] rank_ff, rank_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rsp_ent_ff, rsp_ent_in;
   logic             rsp_ev_ff, rsp_ev_in;
   logic             rsp_last_ff, rsp_last_in;

   // name cut at the first zero byte
   logic [NAME_W-1:0]     raw_name;
   logic [NAME_W-1:0]     norm_name;
   logic [NAME_BYTES-1:0] keep;

   assign raw_name = {req_name_word3, req_name_word2, req_name_word1, req_name_word0};

   always_comb begin
      keep[0] = |raw_name[7:0];
      for (int k = 1; k < NAME_BYTES; k++) begin
         keep[k] = keep[k-1] & (|raw_name[8*k +: 8]);
      end
      for (int k = 0; k < NAME_BYTES; k++) begin
         norm_name[8*k +: 8] = raw_name[8*k +: 8] & {8{keep[k]}};
      end
   end

   // shared compare unit on the row coming out of the memory
   logic name_hit;
   logic scan_done;
   logic eligible;
   logic take_best;
   logic rsp_free;

   assign name_hit  = (rd_data_ff.name == ins_ff.name);
   assign scan_done = (scan_idx_ff == cnt_ff) && !cmp_vld_ff;
   assign eligible  = !have_prev_ff || (rd_data_ff.sig < prev_sig_ff) ||
                      ((rd_data_ff.sig == prev_sig_ff) && (cmp_idx_ff > prev_idx_ff));
   assign take_best = eligible && (!best_any_ff || (rd_data_ff.sig > best_ff.sig));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      ins_in       = ins_ff;
      weak_any_in  = weak_any_ff;
      weak_idx_in  = weak_idx_ff;
      weak_sig_in  = weak_sig_ff;
      best_any_in  = best_any_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      have_prev_in = have_prev_ff;
      prev_sig_in  = prev_sig_ff;
      prev_idx_in  = prev_idx_ff;
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ent_in   = rsp_ent_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = scan_idx_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_data      = ins_ff;

      // issue one row read a cycle while scanning
      if ((state_ff == ST_INS || state_ff == ST_RPT) && (scan_idx_ff != cnt_ff)) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
         cmp_vld_in  = 1'b1;
         cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               scan_idx_in = '0;
               unique case (req_operation)
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  OP_INSERT: begin
                     if (keep[0]) begin
                        ins_in      = '{name: norm_name, sig: req_signal_dbm,
                                        sec: req_secure_in};
                        weak_any_in = 1'b0;
                        state_in    = ST_INS;
                     end
                  end
                  OP_REPORT: begin
                     have_prev_in = 1'b0;
                     best_any_in  = 1'b0;
                     rank_in      = '0;
                     state_in     = (cnt_ff == '0) ? ST_EMIT : ST_RPT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS: begin
            priority if (cmp_vld_ff && name_hit) begin
               // known name: keep the stronger signal, merge the flag
               wr_en       = 1'b1;
               wr_addr     = cmp_idx_ff;
               wr_data     = rd_data_ff;
               wr_data.sig = (ins_ff.sig > rd_data_ff.sig) ? ins_ff.sig : rd_data_ff.sig;
               wr_data.sec = rd_data_ff.sec | ins_ff.sec;
               state_in    = ST_IDLE;
            end else if (cmp_vld_ff) begin
               // track the first weakest row
               if (!weak_any_ff || (rd_data_ff.sig < weak_sig_ff)) begin
                  weak_any_in = 1'b1;
                  weak_idx_in = cmp_idx_ff;
                  weak_sig_in = rd_data_ff.sig;
               end
            end else if (scan_done) begin
               state_in = ST_IDLE;
               if (cnt_ff < CNT_W'(MAX_ENTRIES)) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[IDX_W-1:0];
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else if (ins_ff.sig > weak_sig_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = weak_idx_ff;
               end
            end
         end

         ST_RPT: begin
            // selection pass: next row after the previous one in report order
            if (cmp_vld_ff && take_best) begin
               best_any_in = 1'b1;
               best_in     = rd_data_ff;
               best_idx_in = cmp_idx_ff;
            end
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_ent_in  = '0;
                  rsp_ev_in   = 1'b0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_ent_in   = best_ff;
                  rsp_ev_in    = 1'b1;
                  rsp_last_in  = (rank_ff + CNT_W'(1) == cnt_ff);
                  rank_in      = rank_ff + CNT_W'(1);
                  have_prev_in = 1'b1;
                  prev_sig_in  = best_ff.sig;
                  prev_idx_in  = best_idx_ff;
                  best_any_in  = 1'b0;
                  scan_idx_in  = '0;
                  state_in     = (rank_ff + CNT_W'(1) == cnt_ff) ? ST_IDLE : ST_RPT;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      ins_ff       <= ins_in;
      weak_any_ff  <= weak_any_in;
      weak_idx_ff  <= weak_idx_in;
      weak_sig_ff  <= weak_sig_in;
      best_any_ff  <= best_any_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      have_prev_ff <= have_prev_in;
      prev_sig_ff  <= prev_sig_in;
      prev_idx_ff  <= prev_idx_in;
      rank_ff      <= rank_in;
      rsp_ent_ff   <= rsp_ent_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // outputs
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word0   = rsp_ent_ff.name[0*NAME_WORD_W +: NAME_WORD_W];
   assign rsp_out_word1   = rsp_ent_ff.name[1*NAME_WORD_W +: NAME_WORD_W];
   assign rsp_out_word2   = rsp_ent_ff.name[2*NAME_WORD_W +: NAME_WORD_W];
   assign rsp_out_word3   = rsp_ent_ff.name[3*NAME_WORD_W +: NAME_WORD_W];
   assign rsp_out_signal  = rsp_ent_ff.sig;
   assign rsp_out_secure  = rsp_ent_ff.sec;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### rtl/dktt_checker.sv
// ----------------------------------------------------------------------------
// dktt_checker
// Port-level checks of the network table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dktt_checker
   import dktt_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [NAME_WORD_W-1:0]  rsp_out_word0,
   input logic signed [SIG_W-1:0] rsp_out_signal,
   input logic                    rsp_out_secure,
   input logic                    rsp_entry_valid,
   input logic                    rsp_last
);

   // a stalled word holds
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_word0) && $stable(rsp_out_signal) && $stable(rsp_last), "rsp word changed under stall")

   // the empty-table word is the last and carries zeros
   `CHK_IMPL(a_empty_last, rsp_valid && !rsp_entry_valid, rsp_last && (rsp_out_word0 == '0) && (rsp_out_signal == '0) && !rsp_out_secure, "empty report word malformed")

   // no new command while a report still has words to give
   `CHK_IMPL(a_rpt_busy, rsp_valid && !rsp_last, req_stall, "command taken mid report")

endmodule

bind dedup_top_k_network_table dktt_checker u_dktt_checker (.*);
